// ----- design/trme_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// trme_pkg: shared types and constants of the register machine execute block.
// Used by trme_alu, trme_regfile and tiny_register_machine_execute.

package trme_pkg;

	localparam int DATA_W   = 32;  // data path and operand width
	localparam int ADD_W    = DATA_W + 1;
	localparam int CNT_W    = $clog2(DATA_W);
	localparam int LINE_OUT_W = 9; // width of the reported line number
	localparam int WIDX_W   = 4;   // width of the reported write index

	typedef enum logic [3:0] {
		F_ADD    = 4'd0,
		F_SUB    = 4'd1,
		F_MUL    = 4'd2,
		F_DIV    = 4'd3,
		F_MOVE   = 4'd4,
		F_CMP    = 4'd5,
		F_JUMP   = 4'd6,
		F_BRANCH = 4'd7,
		F_HALT   = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_BAD_REG  = 2'd2,
		ERR_BAD_JUMP = 2'd3
	} err_code_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_CMP,
		ALU_MUL,
		ALU_DIV
	} alu_kind_t;

	typedef struct packed {
		logic      start;
		alu_kind_t kind;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_stat_t;

endpackage

`default_nettype wire

// ----- design/trme_regfile.sv -----
`timescale 1ns / 1ps
`default_nettype none
// trme_regfile: register store, one write port and one registered read port.
// Per-entry valid bits make every register read as zero after reset. Uses trme_pkg.

module trme_regfile
	import trme_pkg::*;
#(
	parameter int NUM_REGS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        we,
	input  wire logic [$clog2(NUM_REGS)-1:0] waddr,
	input  wire logic [DATA_W-1:0]           wdata,
	input  wire logic [$clog2(NUM_REGS)-1:0] raddr,
	output logic      [DATA_W-1:0]           rdata
);

	logic [DATA_W-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	// never-written entries read as their reset value
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- design/trme_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// trme_alu: iterative arithmetic unit built around one shared 33-bit adder.
// Add/sub/compare in one pass, shift-add multiply and restoring divide. Uses trme_pkg.

module trme_alu
	import trme_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alu_cmd_t          cmd,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	output alu_stat_t              stat,
	output logic      [DATA_W-1:0] result
);

	typedef enum logic [2:0] {
		P_IDLE,
		P_ONE,
		P_NEG_A,
		P_NEG_B,
		P_LOOP,
		P_FIX,
		P_DONE
	} phase_t;

	phase_t            phase_q;
	alu_kind_t         kind_q;
	logic [DATA_W-1:0] a_q;   // multiplicand, or dividend shifting into quotient
	logic [DATA_W-1:0] b_q;   // multiplier or divisor
	logic [DATA_W-1:0] acc_q; // product or partial remainder
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic              dz_q;

	logic [ADD_W-1:0] add_x;
	logic [ADD_W-1:0] add_y;
	logic             add_sub;
	logic [ADD_W-1:0] sum;

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (phase_q)
			P_ONE: begin
				add_x   = {a_q[DATA_W-1], a_q};
				add_y   = {b_q[DATA_W-1], b_q};
				add_sub = (kind_q != ALU_ADD);
			end
			P_NEG_A, P_FIX: begin
				add_y   = {1'b0, a_q};
				add_sub = 1'b1;
			end
			P_NEG_B: begin
				add_y   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			P_LOOP: begin
				if (kind_q == ALU_MUL) begin
					add_x = {1'b0, acc_q};
					add_y = {1'b0, a_q};
				end else begin
					// trial subtract of the divisor from the shifted remainder
					add_x   = {acc_q, a_q[DATA_W-1]};
					add_y   = {1'b0, b_q};
					add_sub = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign sum = add_x + (add_sub ? ~add_y : add_y) + ADD_W'(add_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			kind_q  <= ALU_ADD;
			a_q     <= '0;
			b_q     <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			dz_q    <= 1'b0;
		end else begin
			unique case (phase_q)
				P_IDLE: begin
					if (cmd.start) begin
						a_q    <= a;
						b_q    <= b;
						kind_q <= cmd.kind;
						acc_q  <= '0;
						cnt_q  <= '0;
						neg_q  <= a[DATA_W-1] ^ b[DATA_W-1];
						dz_q   <= 1'b0;
						if (cmd.kind == ALU_MUL) begin
							phase_q <= P_LOOP;
						end else if (cmd.kind == ALU_DIV) begin
							if (b == '0) begin
								dz_q    <= 1'b1;
								phase_q <= P_DONE;
							end else begin
								phase_q <= P_NEG_A;
							end
						end else begin
							phase_q <= P_ONE;
						end
					end
				end
				P_ONE: begin
					// sign of the 33-bit difference gives a < b
					acc_q   <= (kind_q == ALU_CMP) ? DATA_W'(sum[DATA_W]) : sum[DATA_W-1:0];
					phase_q <= P_DONE;
				end
				P_NEG_A: begin
					if (a_q[DATA_W-1]) begin
						a_q <= sum[DATA_W-1:0];
					end
					phase_q <= P_NEG_B;
				end
				P_NEG_B: begin
					if (b_q[DATA_W-1]) begin
						b_q <= sum[DATA_W-1:0];
					end
					phase_q <= P_LOOP;
				end
				P_LOOP: begin
					if (kind_q == ALU_MUL) begin
						if (b_q[0]) begin
							acc_q <= sum[DATA_W-1:0];
						end
						a_q <= {a_q[DATA_W-2:0], 1'b0};
						b_q <= {1'b0, b_q[DATA_W-1:1]};
					end else begin
						if (!sum[DATA_W]) begin
							acc_q <= sum[DATA_W-1:0];
						end else begin
							acc_q <= {acc_q[DATA_W-2:0], a_q[DATA_W-1]};
						end
						a_q <= {a_q[DATA_W-2:0], ~sum[DATA_W]};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DATA_W - 1)) begin
						phase_q <= (kind_q == ALU_MUL) ? P_DONE : P_FIX;
					end
				end
				P_FIX: begin
					acc_q   <= neg_q ? sum[DATA_W-1:0] : a_q;
					phase_q <= P_DONE;
				end
				P_DONE: begin
					phase_q <= P_IDLE;
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	assign stat.done     = (phase_q == P_DONE);
	assign stat.div_zero = dz_q;
	assign result        = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> phase_q == P_IDLE)
		else $error("alu started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> !stat.done)
		else $error("alu done held for more than one cycle");

endmodule

`default_nettype wire

// ----- design/tiny_register_machine_execute.sv -----
`timescale 1ns / 1ps
`default_nettype none
// tiny_register_machine_execute: execute stage of a small register machine.
// Instantiates trme_regfile and trme_alu; uses trme_pkg.
//
//  channel   handshake                    payload
//  item      item_valid / item_ready      func, operand_a, a_is_immediate,
//                                         operand_b, b_is_immediate
//  result    result_valid / result_ready  r0_value, write_valid, write_index,
//                                         write_value, next_line, branch_taken,
//                                         halted, error_code
//
// One request at a time. Add, sub, compare, multiply and divide use trme_alu;
// move, jump, branch and halt do not. Multiply and divide make DATA_W loop
// passes through the shared adder; a zero divisor skips the loop. Halted
// requests skip the ALU. Operands come from the register store one read per cycle.
// Reset clears the registers, sets the line counter to one and clears the halt flag.
// A result waiting on result_ready does not block acceptance of the next request;
// that request stalls before commit until the result register is free.

module tiny_register_machine_execute
	import trme_pkg::*;
#(
	parameter int NUM_REGS      = 10,
	parameter int PROGRAM_LINES = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic [3:0]            func,
	input  wire logic signed [DATA_W-1:0] operand_a,
	input  wire logic                  a_is_immediate,
	input  wire logic signed [DATA_W-1:0] operand_b,
	input  wire logic                  b_is_immediate,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic signed [DATA_W-1:0]   r0_value,
	output logic                       write_valid,
	output logic [WIDX_W-1:0]          write_index,
	output logic signed [DATA_W-1:0]   write_value,
	output logic [LINE_OUT_W-1:0]      next_line,
	output logic                       branch_taken,
	output logic                       halted,
	output logic [1:0]                 error_code
);

	localparam int IDX_W  = $clog2(NUM_REGS);
	localparam int LINE_W = $clog2(PROGRAM_LINES + 1);
	localparam logic [DATA_W-1:0] NREGS_D = DATA_W'(NUM_REGS);
	localparam logic [DATA_W-1:0] LINES_D = DATA_W'(PROGRAM_LINES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPA,
		S_OPB,
		S_EXEC,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [3:0]        func_q;
	logic [DATA_W-1:0] opa_q;
	logic              ai_q;
	logic [DATA_W-1:0] opb_q;
	logic              bi_q;
	logic [DATA_W-1:0] a_val_q;
	err_code_t         err_q;
	logic              wv_q;
	logic [IDX_W-1:0]  widx_q;
	logic [DATA_W-1:0] wval_q;
	logic [LINE_W-1:0] next_q;
	logic              taken_q;
	logic              hnext_q;
	logic [LINE_W-1:0] line_q;
	logic              halt_q;
	logic [DATA_W-1:0] r0_q;

	logic                  result_valid_q;
	logic [DATA_W-1:0]     r0_value_q;
	logic                  write_valid_q;
	logic [WIDX_W-1:0]     write_index_q;
	logic [DATA_W-1:0]     write_value_q;
	logic [LINE_OUT_W-1:0] next_line_q;
	logic                  branch_taken_q;
	logic                  halted_q;
	err_code_t             error_code_q;

	logic [IDX_W-1:0]  rf_raddr;
	logic [DATA_W-1:0] rf_rdata;
	logic              rf_we;
	alu_cmd_t          alu_cmd;
	alu_stat_t         alu_stat;
	logic [DATA_W-1:0] alu_result;

	logic              a_bad;
	logic              b_bad;
	logic              reads_a;
	logic              reads_b;
	logic [DATA_W-1:0] a_val;
	logic [DATA_W-1:0] b_val;
	logic [LINE_W-1:0] seq_line;
	logic              target_ok;
	logic              slot_free;
	logic              commit;
	logic [DATA_W-1:0] raw_sel;

	// register index: unsigned, out of range reads as zero
	assign a_bad = (opa_q >= NREGS_D);
	assign b_bad = (opb_q >= NREGS_D);

	assign reads_a = !halt_q && (func_q == F_ADD || func_q == F_SUB || func_q == F_MUL ||
		func_q == F_DIV || func_q == F_CMP || func_q == F_JUMP || func_q == F_BRANCH);
	assign reads_b = !halt_q && (func_q <= F_CMP);

	assign a_val = ai_q ? opa_q : (a_bad ? '0 : rf_rdata);
	assign b_val = bi_q ? opb_q : (b_bad ? '0 : rf_rdata);

	// read a at acceptance, b in the cycle after
	assign raw_sel  = (state_q == S_IDLE) ? operand_a : opb_q;
	assign rf_raddr = (raw_sel >= NREGS_D) ? '0 : raw_sel[IDX_W-1:0];

	assign seq_line  = (line_q >= LINE_W'(PROGRAM_LINES)) ? LINE_W'(1) : line_q + 1'b1;
	assign target_ok = !a_val_q[DATA_W-1] && (a_val_q != '0) && (a_val_q <= LINES_D);

	assign slot_free = !result_valid_q || result_ready;
	assign commit    = (state_q == S_FIN) && slot_free;
	assign rf_we     = commit && wv_q;

	always_comb begin
		alu_cmd.start = 1'b0;
		alu_cmd.kind  = ALU_ADD;
		if (state_q == S_OPB && !halt_q) begin
			case (func_q) inside
				F_ADD: begin alu_cmd.start = 1'b1; alu_cmd.kind = ALU_ADD; end
				F_SUB: begin alu_cmd.start = 1'b1; alu_cmd.kind = ALU_SUB; end
				F_MUL: begin alu_cmd.start = 1'b1; alu_cmd.kind = ALU_MUL; end
				F_DIV: begin alu_cmd.start = 1'b1; alu_cmd.kind = ALU_DIV; end
				F_CMP: begin alu_cmd.start = 1'b1; alu_cmd.kind = ALU_CMP; end
				default: begin
				end
			endcase
		end
	end

	trme_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (rf_we),
		.waddr (widx_q),
		.wdata (wval_q),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	trme_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (alu_cmd),
		.a     (a_val_q),
		.b     (b_val),
		.stat  (alu_stat),
		.result(alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			func_q         <= '0;
			opa_q          <= '0;
			ai_q           <= 1'b0;
			opb_q          <= '0;
			bi_q           <= 1'b0;
			a_val_q        <= '0;
			err_q          <= ERR_NONE;
			wv_q           <= 1'b0;
			widx_q         <= '0;
			wval_q         <= '0;
			next_q         <= LINE_W'(1);
			taken_q        <= 1'b0;
			hnext_q        <= 1'b0;
			line_q         <= LINE_W'(1);
			halt_q         <= 1'b0;
			r0_q           <= '0;
			result_valid_q <= 1'b0;
			r0_value_q     <= '0;
			write_valid_q  <= 1'b0;
			write_index_q  <= '0;
			write_value_q  <= '0;
			next_line_q    <= '0;
			branch_taken_q <= 1'b0;
			halted_q       <= 1'b0;
			error_code_q   <= ERR_NONE;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						func_q  <= func;
						opa_q   <= operand_a;
						ai_q    <= a_is_immediate;
						opb_q   <= operand_b;
						bi_q    <= b_is_immediate;
						state_q <= S_OPA;
					end
				end
				S_OPA: begin
					a_val_q <= a_val;
					err_q   <= (reads_a && !ai_q && a_bad) ? ERR_BAD_REG : ERR_NONE;
					state_q <= S_OPB;
				end
				S_OPB: begin
					wv_q    <= 1'b0;
					widx_q  <= '0;
					wval_q  <= '0;
					taken_q <= 1'b0;
					next_q  <= halt_q ? line_q : seq_line;
					hnext_q <= halt_q;
					state_q <= S_FIN;
					if (reads_b && !bi_q && b_bad) begin
						err_q <= ERR_BAD_REG;
					end
					if (!halt_q) begin
						unique case (func_q) inside
							F_ADD, F_SUB, F_MUL, F_DIV, F_CMP: begin
								wv_q    <= 1'b1;
								state_q <= S_EXEC;
							end
							F_MOVE: begin
								// destination is always an index
								if (a_bad) begin
									err_q <= ERR_BAD_REG;
								end else begin
									wv_q   <= 1'b1;
									widx_q <= opa_q[IDX_W-1:0];
									wval_q <= b_val;
								end
							end
							F_JUMP, F_BRANCH: begin
								if ((func_q == F_JUMP || r0_q == DATA_W'(1)) &&
									err_q == ERR_NONE) begin
									if (target_ok) begin
										next_q  <= a_val_q[LINE_W-1:0];
										taken_q <= 1'b1;
									end else begin
										err_q <= ERR_BAD_JUMP;
									end
								end
							end
							default: begin
								// halt and undefined opcodes
								hnext_q <= 1'b1;
								next_q  <= line_q;
							end
						endcase
					end
				end
				S_EXEC: begin
					if (alu_stat.done) begin
						wval_q <= alu_result;
						if (alu_stat.div_zero && err_q == ERR_NONE) begin
							err_q <= ERR_DIV_ZERO;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						line_q <= next_q;
						halt_q <= hnext_q;
						if (wv_q && widx_q == '0) begin
							r0_q <= wval_q;
						end
						result_valid_q <= 1'b1;
						r0_value_q     <= (wv_q && widx_q == '0) ? wval_q : r0_q;
						write_valid_q  <= wv_q;
						write_index_q  <= WIDX_W'(widx_q);
						write_value_q  <= wval_q;
						next_line_q    <= LINE_OUT_W'(next_q);
						branch_taken_q <= taken_q;
						halted_q       <= hnext_q;
						error_code_q   <= err_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign r0_value     = r0_value_q;
	assign write_valid  = write_valid_q;
	assign write_index  = write_index_q;
	assign write_value  = write_value_q;
	assign next_line    = next_line_q;
	assign branch_taken = branch_taken_q;
	assign halted       = halted_q;
	assign error_code   = error_code_q;

	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && write_valid |-> int'(write_index) < NUM_REGS)
		else $error("write index beyond register count");

	a_taken_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && branch_taken |-> error_code == ERR_NONE && !halted)
		else $error("branch taken alongside an error or halt");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

endmodule

`default_nettype wire
